### rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  // Channel and field sizing
  localparam int MAX_CH     = 8;
  localparam int CH_W       = $clog2(MAX_CH);
  localparam int CNT_W      = 4;
  localparam int SAMPLE_W   = 32;
  localparam int AMP_W      = 31;
  localparam int FRAMES_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Register reset values
  localparam logic [CNT_W-1:0]    CH_COUNT_RST = 4'd2;
  localparam logic [FRAMES_W-1:0] FRAMES_RST   = 20'd1024;

  localparam logic [AMP_W-1:0] FULL_SCALE = '1;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH_COUNT     = 2'd0,
    CFG_BLOCK_FRAMES = 2'd1
  } cfg_reg_t;

  // Queue entry: sample held offset-binary so unsigned compares order it
  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample_b;
    logic [CNT_W-1:0]    req;
  } q_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_END,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

### rtl/bpm_front.sv
`default_nettype none

module bpm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [bpm_pkg::CNT_W-1:0]      in_requested_count,
  input  logic                           q_full,
  output logic                           q_push,
  output bpm_pkg::q_entry_t              q_data
);
  import bpm_pkg::*;

  logic     hold_valid_r;
  q_entry_t hold_r;
  q_entry_t entry_nxt;

  // Classify the transaction and bias the sample to offset-binary
  always_comb begin
    entry_nxt.op       = op_t'(in_operation);
    entry_nxt.sample_b = {~in_sample[SAMPLE_W-1], in_sample[SAMPLE_W-2:0]};
    entry_nxt.req      = in_requested_count;
  end

  // One-entry input stage, drains into the queue when there is room
  assign q_push   = hold_valid_r && !q_full;
  assign in_ready = !hold_valid_r || q_push;
  assign q_data   = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/bpm_queue.sv
`default_nettype none

module bpm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bpm_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output bpm_pkg::q_entry_t head
);
  import bpm_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");

endmodule

`default_nettype wire

### rtl/bpm_back.sv
`default_nettype none

module bpm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            q_empty,
  input  bpm_pkg::q_entry_t               q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_available,
  output logic [bpm_pkg::CNT_W-1:0]       out_reported_channels,
  output logic [bpm_pkg::CH_W-1:0]        out_channel,
  output logic [bpm_pkg::AMP_W-1:0]       out_amplitude,
  output logic                            out_has_value,
  output logic                            out_last
);
  import bpm_pkg::*;

  typedef struct packed {
    logic              available;
    logic [CNT_W-1:0]  reported;
    logic [CH_W-1:0]   channel;
    logic [AMP_W-1:0]  amplitude;
    logic              has_value;
    logic              last;
  } result_t;

  function automatic logic [AMP_W-1:0] magnitude(input logic [SAMPLE_W-1:0] lo,
                                                 input logic [SAMPLE_W-1:0] hi);
    logic [AMP_W-1:0] neg;
    logic [AMP_W-1:0] pos;
    if (lo == '0) neg = FULL_SCALE;
    else if (!lo[SAMPLE_W-1]) neg = AMP_W'({1'b1, {(SAMPLE_W-1){1'b0}}} - lo);
    else neg = '0;
    pos = hi[SAMPLE_W-1] ? hi[SAMPLE_W-2:0] : '0;
    return (pos > neg) ? pos : neg;
  endfunction

  // Registers
  logic [CNT_W-1:0]    ch_count_r;
  logic [FRAMES_W-1:0] frames_r;
  logic [SAMPLE_W-1:0] min_r  [MAX_CH];
  logic [SAMPLE_W-1:0] max_r  [MAX_CH];
  logic [AMP_W-1:0]    held_r [MAX_CH];
  logic [CH_W-1:0]     ch_idx_r;
  logic [FRAMES_W-1:0] frame_cnt_r;
  logic                peaks_ready_r;
  back_state_t         state_r, state_nxt;
  logic [CH_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]    req_r, req_nxt;
  logic                out_valid_r;
  result_t             out_res_r;

  // Derived controls
  logic [CNT_W-1:0]    n_eff;
  logic [FRAMES_W-1:0] frames_eff;
  logic [CH_W-1:0]     idx;
  logic [CH_W-1:0]     idx_nxt;
  logic                wrap;
  logic [FRAMES_W-1:0] frame_inc;
  logic                block_done;
  logic [CNT_W-1:0]    req_sat;
  logic                slot_free;
  logic                cfg_hit;
  logic                do_sample;
  logic                do_end;
  logic                load_out;
  logic                clr_ready;
  logic                emit_last;
  result_t             res;
  logic [AMP_W-1:0]    mag [MAX_CH];

  // Effective channel count and block length
  always_comb begin
    if (ch_count_r == '0) n_eff = CNT_W'(1);
    else if (ch_count_r > CNT_W'(MAX_CH)) n_eff = CNT_W'(MAX_CH);
    else n_eff = ch_count_r;
    frames_eff = (frames_r == '0) ? FRAMES_W'(1) : frames_r;
  end

  // Interleave position and frame counting
  always_comb begin
    idx        = (CNT_W'(ch_idx_r) >= n_eff) ? '0 : ch_idx_r;
    wrap       = (CNT_W'(idx) + 1'b1 >= n_eff);
    idx_nxt    = wrap ? '0 : idx + 1'b1;
    frame_inc  = frame_cnt_r + FRAMES_W'(wrap);
    block_done = (frame_inc >= frames_eff);
    req_sat    = (q_head.req > n_eff) ? n_eff : q_head.req;
  end

  // Per-channel block magnitudes
  always_comb begin
    for (int c = 0; c < MAX_CH; c++) begin
      mag[c] = magnitude(min_r[c], max_r[c]);
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign cfg_hit   = cfg_we && ((cfg_index == CFG_CH_COUNT) ||
                                (cfg_index == CFG_BLOCK_FRAMES));
  assign emit_last = (CNT_W'(k_r) + 1'b1 == req_r);

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    req_nxt   = req_r;
    q_pop     = 1'b0;
    do_sample = 1'b0;
    do_end    = 1'b0;
    load_out  = 1'b0;
    clr_ready = 1'b0;
    res       = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.op == OP_SAMPLE) begin
            q_pop     = 1'b1;
            do_sample = 1'b1;
            if (block_done) state_nxt = B_END;
          end else if (slot_free) begin
            q_pop    = 1'b1;
            load_out = 1'b1;
            res.last = 1'b1;
            if (peaks_ready_r) begin
              clr_ready     = 1'b1;
              res.available = 1'b1;
              res.reported  = n_eff;
              if (req_sat != '0) begin
                res.amplitude = held_r[0];
                res.has_value = 1'b1;
                res.last      = (req_sat == CNT_W'(1));
                if (req_sat != CNT_W'(1)) begin
                  req_nxt   = req_sat;
                  k_nxt     = CH_W'(1);
                  state_nxt = B_EMIT;
                end
              end
            end
          end
        end
      end
      B_END: begin
        do_end    = 1'b1;
        state_nxt = B_IDLE;
      end
      B_EMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          res.available = 1'b1;
          res.reported  = n_eff;
          res.channel   = k_r;
          res.amplitude = held_r[k_r];
          res.has_value = 1'b1;
          res.last      = emit_last;
          if (emit_last) state_nxt = B_IDLE;
          else k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      k_r           <= '0;
      req_r         <= '0;
      ch_count_r    <= CH_COUNT_RST;
      frames_r      <= FRAMES_RST;
      ch_idx_r      <= '0;
      frame_cnt_r   <= '0;
      peaks_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int c = 0; c < MAX_CH; c++) begin
        min_r[c]  <= '1;
        max_r[c]  <= '0;
        held_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      req_r   <= req_nxt;

      if (cfg_hit) begin
        // Register write restarts the block in progress
        if (cfg_index == CFG_CH_COUNT) ch_count_r <= cfg_wdata[CNT_W-1:0];
        else frames_r <= cfg_wdata[FRAMES_W-1:0];
        ch_idx_r    <= '0;
        frame_cnt_r <= '0;
        for (int c = 0; c < MAX_CH; c++) begin
          min_r[c] <= '1;
          max_r[c] <= '0;
        end
      end else if (do_sample) begin
        if (q_head.sample_b < min_r[idx]) min_r[idx] <= q_head.sample_b;
        if (q_head.sample_b > max_r[idx]) max_r[idx] <= q_head.sample_b;
        ch_idx_r    <= idx_nxt;
        frame_cnt_r <= frame_inc;
      end else if (do_end) begin
        // Fold block magnitudes into held peaks, then reload the block
        for (int c = 0; c < MAX_CH; c++) begin
          if ((CNT_W'(c) < n_eff) && (!peaks_ready_r || mag[c] > held_r[c])) begin
            held_r[c] <= mag[c];
          end
          min_r[c] <= '1;
          max_r[c] <= '0;
        end
        peaks_ready_r <= 1'b1;
        ch_idx_r      <= '0;
        frame_cnt_r   <= '0;
      end

      if (clr_ready) peaks_ready_r <= 1'b0;

      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_available         = out_res_r.available;
  assign out_reported_channels = out_res_r.reported;
  assign out_channel           = out_res_r.channel;
  assign out_amplitude         = out_res_r.amplitude;
  assign out_has_value         = out_res_r.has_value;
  assign out_last              = out_res_r.last;

  a_end_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_END |=> state_r == B_IDLE && peaks_ready_r)
    else $error("block end did not complete in one cycle");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> CNT_W'(k_r) < req_r && req_r <= n_eff)
    else $error("read emission index out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(ch_idx_r) < n_eff)
    else $error("interleave index beyond channel count");

  a_emit_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != B_IDLE |-> !q_pop)
    else $error("queue popped while busy");

endmodule

`default_nettype wire

### rtl/block_peak_meter.sv
// Block peak meter for interleaved signed 32-bit audio.
// Input channel (in_valid/in_ready): in_operation 0 carries one sample for
// the next channel in interleave order; 1 is a read of up to
// in_requested_count held peaks. Results leave on out_valid/out_ready, one
// transaction per channel returned (or one empty result), out_last marking
// the final one of a read.
// Configuration: cfg_we writes register cfg_index (0 channel count,
// 1 frames per block) with cfg_wdata; writing either restarts the current block.
// Write only while the meter is idle.
// Throughput: one sample per cycle while the queue has room; after the last
// sample of a block the back end spends an end state folding all channel
// magnitudes into the held peaks in parallel. A read emits one result per
// cycle out of the output register while out_ready is high.
// With nothing queued ahead of it, a read's first result is registered in the
// input stage, then the queue, then the output register.
// Reset (synchronous, rst_n low): 2 channels, 1024 frames per block, held
// peaks zero, nothing available.
// A stalled receiver holds the result; the queue keeps taking samples until
// it and the input stage fill, then in_ready drops.
`default_nettype none

module block_peak_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [bpm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [bpm_pkg::CNT_W-1:0]           in_requested_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_available,
  output logic [bpm_pkg::CNT_W-1:0]           out_reported_channels,
  output logic [bpm_pkg::CH_W-1:0]            out_channel,
  output logic [bpm_pkg::AMP_W-1:0]           out_amplitude,
  output logic                                out_has_value,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bpm_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_data;
  q_entry_t q_head;

  bpm_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_sample          (in_sample),
    .in_requested_count (in_requested_count),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_data)
  );

  bpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  bpm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_available         (out_available),
    .out_reported_channels (out_reported_channels),
    .out_channel           (out_channel),
    .out_amplitude         (out_amplitude),
    .out_has_value         (out_has_value),
    .out_last              (out_last)
  );

endmodule

`default_nettype wire
